>>> rtl/hff_pkg.sv
// Shared constants, field layout type and a character helper for the hex field formatter.
package hff_pkg;

    localparam int MAX_FIELD  = 64;
    localparam int MAX_DIGITS = 16;
    localparam int POS_W      = 7;

    localparam logic [1:0] PM_NONE       = 2'd0;
    localparam logic [1:0] PM_NONZERO    = 2'd1;
    localparam logic [1:0] PM_ALWAYS     = 2'd2;
    localparam logic [1:0] PM_ALWAYS_ALT = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    // Boundaries of each section of the field, as character positions.
    typedef struct packed {
        logic             upper;
        logic [POS_W-1:0] lead;
        logic [POS_W-1:0] pfx_end;
        logic [POS_W-1:0] zero_end;
        logic [POS_W-1:0] dig_end;
        logic [POS_W-1:0] total;
    } layout_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10)
            begin
                c = CH_ZERO + {4'd0, d};
            end
            else
            begin
                c = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
            end
            return c;
        end
    endfunction

endpackage

>>> rtl/hff_decode.sv
// Computes the section layout and aligned digits of one field from its settings.
module hff_decode (
    input  logic [63:0]            value,
    input  logic                   upper_case,
    input  logic [1:0]             prefix_mode,
    input  logic                   left_justify,
    input  logic                   zero_pad,
    input  logic [6:0]             field_width,
    input  logic                   precision_given,
    input  logic [5:0]             digit_precision,
    output hff_pkg::layout_t       layout,
    output logic [63:0]            digits
);

    logic [6:0] w;
    logic [6:0] p;
    logic [4:0] nd_raw;
    logic       nz;
    logic [6:0] nd;
    logic [6:0] prefix;
    logic [6:0] zeros;
    logic [6:0] body;
    logic [6:0] spaces;
    logic [6:0] lead;
    logic [6:0] shamt;

    always_comb
    begin
        w = (field_width > 7'(hff_pkg::MAX_FIELD)) ? 7'(hff_pkg::MAX_FIELD) : field_width;
        p = ({1'b0, digit_precision} > 7'(hff_pkg::MAX_FIELD - 2))
            ? 7'(hff_pkg::MAX_FIELD - 2) : {1'b0, digit_precision};

        nd_raw = 5'd0;
        for (int i = 0; i < hff_pkg::MAX_DIGITS; i++)
        begin
            if (value[4*i +: 4] != 4'd0)
            begin
                nd_raw = 5'(i + 1);
            end
        end
        nz = (nd_raw != 5'd0);

        if (nz)
        begin
            nd = {2'b00, nd_raw};
        end
        else
        begin
            nd = (precision_given && p == 7'd0) ? 7'd0 : 7'd1;
        end

        prefix = (prefix_mode[1] || (prefix_mode == hff_pkg::PM_NONZERO && nz)) ? 7'd2 : 7'd0;

        zeros = 7'd0;
        if (precision_given)
        begin
            if (p > nd)
            begin
                zeros = p - nd;
            end
        end
        else if (zero_pad && !left_justify && w > prefix + nd)
        begin
            zeros = w - prefix - nd;
        end

        body   = prefix + zeros + nd;
        spaces = (w > body) ? w - body : 7'd0;
        lead   = left_justify ? 7'd0 : spaces;

        layout.upper    = upper_case;
        layout.lead     = lead;
        layout.pfx_end  = lead + prefix;
        layout.zero_end = lead + prefix + zeros;
        layout.dig_end  = lead + body;
        layout.total    = body + spaces;

        // Move the most significant printed digit to the top nibble.
        shamt  = (7'd16 - nd) << 2;
        digits = value << shamt;
    end

endmodule

>>> rtl/hff_emit.sv
// Streams the characters of one field into the output register, one per cycle unless stalled.
module hff_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  hff_pkg::layout_t       layout,
    input  logic [63:0]            digits,
    output logic                   free,
    output logic                   char_valid,
    input  logic                   char_stall,
    output logic [7:0]             character,
    output logic                   last
);

    logic                  busy_reg;
    logic                  busy_next;
    logic [6:0]            pos_reg;
    logic [6:0]            pos_next;
    hff_pkg::layout_t      lay_reg;
    logic [63:0]           dig_reg;
    logic [63:0]           dig_next;
    logic                  char_valid_reg;
    logic                  char_valid_next;
    logic [7:0]            char_reg;
    logic [7:0]            char_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  advance;
    logic                  finishing;
    logic                  in_digits;

    always_comb
    begin
        advance   = busy_reg && (!char_valid_reg || !char_stall);
        finishing = advance && (pos_reg == lay_reg.total - 7'd1);
        free      = !busy_reg || finishing;
        in_digits = (pos_reg >= lay_reg.zero_end) && (pos_reg < lay_reg.dig_end);

        if (pos_reg < lay_reg.lead)
        begin
            char_next = hff_pkg::CH_SPACE;
        end
        else if (pos_reg < lay_reg.pfx_end)
        begin
            if (pos_reg == lay_reg.lead)
            begin
                char_next = hff_pkg::CH_ZERO;
            end
            else
            begin
                char_next = lay_reg.upper ? hff_pkg::CH_X_UP : hff_pkg::CH_X_LO;
            end
        end
        else if (pos_reg < lay_reg.zero_end)
        begin
            char_next = hff_pkg::CH_ZERO;
        end
        else if (in_digits)
        begin
            char_next = hff_pkg::hex_char(dig_reg[63:60], lay_reg.upper);
        end
        else
        begin
            char_next = hff_pkg::CH_SPACE;
        end
        last_next = finishing;

        busy_next = busy_reg;
        pos_next  = pos_reg;
        dig_next  = dig_reg;
        if (load)
        begin
            busy_next = (layout.total != 7'd0);
            pos_next  = 7'd0;
            dig_next  = digits;
        end
        else if (advance)
        begin
            pos_next = pos_reg + 7'd1;
            if (finishing)
            begin
                busy_next = 1'b0;
            end
            if (in_digits)
            begin
                dig_next = {dig_reg[59:0], 4'd0};
            end
        end

        if (advance)
        begin
            char_valid_next = 1'b1;
        end
        else if (!char_stall)
        begin
            char_valid_next = 1'b0;
        end
        else
        begin
            char_valid_next = char_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pos_reg        <= 7'd0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pos_reg        <= pos_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        if (load)
        begin
            lay_reg <= layout;
        end
        if (advance)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign char_valid = char_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;

endmodule

>>> rtl/hex_field_formatter.sv
// Top level of the hex field formatter: input register, layout decode and character stream.
//
// The block takes one word on the item channel (item_valid, item_stall) carrying
// a 64-bit value and its printf-style settings, and sends the formatted hexadecimal
// field on the character channel (char_valid, char_stall), one character per word,
// with last set on the final character. A field is up to 64 characters long; a zero
// value with precision 0 given, no prefix and no width yields no words at all.
// An accepted item sits in the input register until the character generator is
// free, then its layout is decoded combinationally as it loads into the generator
// state; its characters then pass the output register, one per cycle while the
// receiver does not stall. The next item is accepted while the current field
// streams and is loaded on the cycle the last character is produced, so fields
// follow without gaps. The sustained rate is set by the character generator: one
// character per cycle while the receiver does not stall. When the receiver stalls,
// the output word holds and the generator pauses; item_stall rises while the input
// register is full and the generator is not free. Reset empties the input register,
// the generator and the output register; no words are pending after it.
module hex_field_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [63:0] value,
    input  logic        upper_case,
    input  logic [1:0]  prefix_mode,
    input  logic        left_justify,
    input  logic        zero_pad,
    input  logic [6:0]  field_width,
    input  logic        precision_given,
    input  logic [5:0]  digit_precision,
    output logic        char_valid,
    input  logic        char_stall,
    output logic [7:0]  character,
    output logic        last
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [63:0]           value_reg;
    logic                  upper_reg;
    logic [1:0]            pmode_reg;
    logic                  left_reg;
    logic                  zpad_reg;
    logic [6:0]            width_reg;
    logic                  pgiven_reg;
    logic [5:0]            prec_reg;
    logic                  accept;
    logic                  load;
    logic                  free;
    hff_pkg::layout_t      layout;
    logic [63:0]           digits;

    always_comb
    begin
        load       = in_valid_reg && free;
        item_stall = in_valid_reg && !free;
        accept     = item_valid && !item_stall;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg  <= value;
            upper_reg  <= upper_case;
            pmode_reg  <= prefix_mode;
            left_reg   <= left_justify;
            zpad_reg   <= zero_pad;
            width_reg  <= field_width;
            pgiven_reg <= precision_given;
            prec_reg   <= digit_precision;
        end
    end

    hff_decode u_decode (
        .value           (value_reg),
        .upper_case      (upper_reg),
        .prefix_mode     (pmode_reg),
        .left_justify    (left_reg),
        .zero_pad        (zpad_reg),
        .field_width     (width_reg),
        .precision_given (pgiven_reg),
        .digit_precision (prec_reg),
        .layout          (layout),
        .digits          (digits)
    );

    hff_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .layout     (layout),
        .digits     (digits),
        .free       (free),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .character  (character),
        .last       (last)
    );

endmodule
